// ===== rtl/hexcan_pkg.sv =====
package hexcan_pkg;

	localparam int STORE_DEPTH = 8;
	localparam int MAX_DATA_BYTES_DEF = 8;
	localparam int IDX_W = $clog2(STORE_DEPTH);

	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_F    = 8'h66;

	localparam logic [5:0] POS_MAX    = 6'd63;
	localparam logic [5:0] ID_DIGITS  = 6'd3;
	localparam logic [5:0] DATA_START = 6'd4;

	// Position within a three-character data group
	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_SEP  = 2'd2
	} phase_t;

	typedef struct packed {
		logic                        valid;
		logic [11:0]                 id;
		logic [3:0]                  count;
		logic [STORE_DEPTH-1:0][7:0] bytes;
		logic                        overflow;
	} frame_t;

	// Bit 4 set for a non-hex character, else the nibble value.
	function automatic logic [4:0] hex_value(logic [7:0] c);
		logic [4:0] v;
		begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				v = {1'b0, 4'(c - CH_ZERO)};
			end else if (c >= CH_A && c <= CH_F) begin
				v = {1'b0, 4'(c - CH_A + 8'd10)};
			end else begin
				v = 5'h10;
			end
			return v;
		end
	endfunction

endpackage

// ===== rtl/hexcan_line.sv =====
module hexcan_line #(
	parameter int MAX_DATA_BYTES = hexcan_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_accept,
	input  logic [7:0]         text_char,
	output logic               line_end,
	output hexcan_pkg::frame_t frame
);

	logic [5:0]  pos_q;
	logic [11:0] id_q;
	logic        id_bad_q;
	logic [3:0]  hi_q;
	logic        stopped_q;
	logic [3:0]  count_q;
	logic        ovf_q;
	hexcan_pkg::phase_t phase_q;
	logic [hexcan_pkg::STORE_DEPTH-1:0][7:0] store_q;

	logic [4:0] hv;
	logic       is_cr;
	logic       in_id;
	logic       in_data;
	logic       room;
	logic       line_ok;

	assign hv      = hexcan_pkg::hex_value(text_char);
	assign is_cr   = (text_char == hexcan_pkg::CH_CR);
	assign in_id   = (pos_q < hexcan_pkg::ID_DIGITS);
	assign in_data = (pos_q >= hexcan_pkg::DATA_START) && (pos_q < hexcan_pkg::POS_MAX);
	assign room    = (count_q < 4'(MAX_DATA_BYTES));
	assign line_end = char_accept && is_cr;

	// Store is zeroed on every line end, so unused bytes already read as zero
	assign line_ok        = (pos_q >= hexcan_pkg::ID_DIGITS) && !id_bad_q;
	assign frame.valid    = line_ok;
	assign frame.id       = line_ok ? id_q : '0;
	assign frame.count    = line_ok ? count_q : '0;
	assign frame.bytes    = line_ok ? store_q : '0;
	assign frame.overflow = line_ok && ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			id_q      <= '0;
			id_bad_q  <= 1'b0;
			hi_q      <= '0;
			stopped_q <= 1'b0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			phase_q   <= hexcan_pkg::PH_HIGH;
			store_q   <= '0;
		end else if (char_accept) begin
			if (is_cr) begin
				pos_q     <= '0;
				id_q      <= '0;
				id_bad_q  <= 1'b0;
				hi_q      <= '0;
				stopped_q <= 1'b0;
				count_q   <= '0;
				ovf_q     <= 1'b0;
				phase_q   <= hexcan_pkg::PH_HIGH;
				store_q   <= '0;
			end else begin
				if (in_id && !id_bad_q) begin
					if (!hv[4]) begin
						id_q <= {id_q[7:0], hv[3:0]};
					end else begin
						id_bad_q <= 1'b1;
					end
				end
				if (in_data) begin
					case (phase_q)
						hexcan_pkg::PH_HIGH: phase_q <= hexcan_pkg::PH_LOW;
						hexcan_pkg::PH_LOW:  phase_q <= hexcan_pkg::PH_SEP;
						default:             phase_q <= hexcan_pkg::PH_HIGH;
					endcase
					if (!stopped_q) begin
						case (phase_q)
							hexcan_pkg::PH_HIGH: begin
								if (!hv[4]) begin
									hi_q <= hv[3:0];
								end else begin
									stopped_q <= 1'b1;
								end
							end
							hexcan_pkg::PH_LOW: begin
								if (hv[4]) begin
									stopped_q <= 1'b1;
								end else if (room) begin
									store_q[count_q[hexcan_pkg::IDX_W-1:0]] <= {hi_q, hv[3:0]};
									count_q <= count_q + 4'd1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							default: begin
								// separator: skip
							end
						endcase
					end
				end
				if (pos_q < hexcan_pkg::POS_MAX) begin
					pos_q <= pos_q + 6'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/hexcan_out_buf.sv =====
module hexcan_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hexcan_pkg::frame_t push_frame,
	output logic               can_take,
	output logic               out_valid,
	input  logic               out_ready,
	output hexcan_pkg::frame_t out_frame
);

	logic               out_valid_q;
	logic               skid_valid_q;
	hexcan_pkg::frame_t out_q;
	hexcan_pkg::frame_t skid_q;
	logic               out_free;

	assign out_free  = out_ready || !out_valid_q;
	assign can_take  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_frame = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: when the output slot is free, load it from the skid, else with the new word; else park the new word
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_frame;
			end
		end else if (push) begin
			skid_q <= push_frame;
		end
	end

endmodule

// ===== rtl/hex_text_can_frame_parser_core.sv =====
// Accepts one character per cycle when in_ready is high; in_ready drops only
// while the skid stage holds a word because the output is stalled.
// A carriage return, once accepted, registers its frame into the output slot, or
// into the skid stage while the output is stalled; other characters give no word.
// Reset (arst_n low, asynchronous) clears the line state, the stored data
// bytes and the valid flags of both output slots.
module hex_text_can_frame_parser_core #(
	parameter int MAX_DATA_BYTES = hexcan_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_valid,
	output logic [11:0] frame_id,
	output logic [3:0]  byte_count,
	output logic [7:0]  data_byte_0,
	output logic [7:0]  data_byte_1,
	output logic [7:0]  data_byte_2,
	output logic [7:0]  data_byte_3,
	output logic [7:0]  data_byte_4,
	output logic [7:0]  data_byte_5,
	output logic [7:0]  data_byte_6,
	output logic [7:0]  data_byte_7,
	output logic        data_overflow
);

	logic               accept;
	logic               line_end;
	hexcan_pkg::frame_t line_frame;
	hexcan_pkg::frame_t out_frame;

	assign accept = in_valid && in_ready;

	hexcan_line #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_line (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_accept (accept),
		.text_char   (text_char),
		.line_end    (line_end),
		.frame       (line_frame)
	);

	hexcan_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (line_end),
		.push_frame (line_frame),
		.can_take   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_frame  (out_frame)
	);

	assign frame_valid   = out_frame.valid;
	assign frame_id      = out_frame.id;
	assign byte_count    = out_frame.count;
	assign data_byte_0   = out_frame.bytes[0];
	assign data_byte_1   = out_frame.bytes[1];
	assign data_byte_2   = out_frame.bytes[2];
	assign data_byte_3   = out_frame.bytes[3];
	assign data_byte_4   = out_frame.bytes[4];
	assign data_byte_5   = out_frame.bytes[5];
	assign data_byte_6   = out_frame.bytes[6];
	assign data_byte_7   = out_frame.bytes[7];
	assign data_overflow = out_frame.overflow;

endmodule
